FILE: design/rtcp_pkg.sv
// Package for the radiotap channel patcher: shared constants and item types.
// No dependencies; compiled before the interfaces and modules.
package rtcp_pkg;

    localparam int unsigned POSITION_BITS_DEF = 16;
    localparam int unsigned CFG_IDX_W         = 1;
    localparam int unsigned CFG_DATA_W        = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CHANNEL_FREQ = 1'b0,
        REG_MARK_INJECTED = 1'b1
    } t_cfg_reg;

    localparam logic [15:0] FREQ_RESET_MHZ = 16'd2412;
    localparam logic [7:0]  MORE_DATA_BIT  = 8'h20;
    localparam int unsigned FIELDS_START_RESET = 8;
    localparam int unsigned MIN_FRAME_BYTES    = 8;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
        logic       frame_status;
    } t_result;

endpackage

FILE: design/rtcp_in_if.sv
// Input channel of the radiotap channel patcher: valid/ready with one frame byte.
// No dependencies.
interface rtcp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

FILE: design/rtcp_out_if.sv
// Output channel of the radiotap channel patcher: valid/ready with one patched byte.
// No dependencies.
interface rtcp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;
    logic       frame_status;

    modport source (output valid, output out_byte, output out_last, output frame_status,
                    input ready);
    modport sink   (input valid, input out_byte, input out_last, input frame_status,
                    output ready);
endinterface

FILE: design/rtcp_in_stage.sv
// Input register of the radiotap channel patcher: holds one accepted item.
// Depends on rtcp_pkg.
module rtcp_in_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  rtcp_pkg::t_item i_item,
    input  logic            i_down_free,
    output logic            o_adv,
    output rtcp_pkg::t_item o_item
);
    import rtcp_pkg::*;

    logic  r_valid;
    logic  n_valid;
    t_item r_item;

    assign o_adv   = r_valid && i_down_free;
    assign o_ready = !r_valid || i_down_free;
    assign o_item  = r_item;

    always_comb begin
        n_valid = r_valid;
        if (o_ready) begin
            n_valid = i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

FILE: design/rtcp_core.sv
// Frame tracker and patch logic: header length, present words, Channel field
// offset, frequency and More Data patches, frame status. Depends on rtcp_pkg.
module rtcp_core #(
    parameter int unsigned POSITION_BITS = rtcp_pkg::POSITION_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [rtcp_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [rtcp_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_adv,
    input  rtcp_pkg::t_item                     i_item,
    output rtcp_pkg::t_result                   o_res
);
    import rtcp_pkg::*;

    localparam int unsigned PW = POSITION_BITS;
    localparam int unsigned XW = ((PW > 16) ? PW : 16) + 2;
    localparam logic [PW-1:0] POS_MAX = {PW{1'b1}};
    localparam logic [XW-1:0] POS_MAX_X = XW'(POS_MAX);

    logic [PW-1:0] r_pos;
    logic [15:0]   r_hdr;
    logic [3:0]    r_present;
    logic          r_chain;
    logic [PW-1:0] r_fstart;
    logic [PW-1:0] r_foff;
    logic          r_fon;
    logic [15:0]   r_freq;
    logic          r_mark;

    logic [PW-1:0] n_pos;
    logic [15:0]   n_hdr;
    logic [3:0]    n_present;
    logic          n_chain;
    logic [PW-1:0] n_fstart;
    logic [PW-1:0] n_foff;
    logic          n_fon;

    logic [XW-1:0] pos_x;
    logic [XW-1:0] fs4;
    logic [XW-1:0] off;
    logic [XW-1:0] off_even;
    logic          ended;
    logic [7:0]    b;
    logic [7:0]    o_byte;
    logic          status;

    assign b     = i_item.in_byte;
    assign pos_x = XW'(r_pos);
    assign fs4   = XW'(r_fstart) + XW'(4);

    always_comb begin
        n_hdr = r_hdr;
        if (pos_x == XW'(2)) begin
            n_hdr = {8'h00, b};
        end else if (pos_x == XW'(3)) begin
            n_hdr = {b, r_hdr[7:0]};
        end

        n_present = (pos_x == XW'(4)) ? b[3:0] : r_present;

        n_chain  = r_chain;
        n_fstart = r_fstart;
        ended    = 1'b0;
        if (pos_x == XW'(7)) begin
            if (b[7]) begin
                n_chain = 1'b1;
            end else begin
                ended = 1'b1;
            end
        end else if (r_chain && (pos_x == XW'(r_fstart) + XW'(3))) begin
            n_fstart = (fs4 > POS_MAX_X) ? POS_MAX : fs4[PW-1:0];
            if (!b[7]) begin
                n_chain = 1'b0;
                ended   = 1'b1;
            end
        end

        off = XW'(n_fstart)
            + (n_present[0] ? XW'(8) : XW'(0))
            + XW'(n_present[1])
            + XW'(n_present[2]);
        off_even = off + XW'(off[0]);

        n_foff = r_foff;
        n_fon  = r_fon;
        if (ended) begin
            n_foff = (off_even > POS_MAX_X) ? POS_MAX : off_even[PW-1:0];
            n_fon  = n_present[3] && (off_even + XW'(2) <= XW'(n_hdr));
        end

        o_byte = b;
        if (n_fon) begin
            if (pos_x == XW'(n_foff)) begin
                o_byte = r_freq[7:0];
            end else if (pos_x == XW'(n_foff) + XW'(1)) begin
                o_byte = r_freq[15:8];
            end
        end
        if (r_mark && (pos_x >= XW'(3)) && (pos_x == XW'(n_hdr) + XW'(1))) begin
            o_byte = o_byte | MORE_DATA_BIT;
        end

        status = i_item.in_last
            && ((pos_x + XW'(1) < XW'(MIN_FRAME_BYTES))
                || ((pos_x >= XW'(3)) && (pos_x + XW'(1) < XW'(n_hdr))));

        n_pos = (r_pos != POS_MAX) ? r_pos + PW'(1) : r_pos;
    end

    assign o_res.out_byte     = o_byte;
    assign o_res.out_last     = i_item.in_last;
    assign o_res.frame_status = status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_hdr     <= '0;
            r_present <= '0;
            r_chain   <= 1'b0;
            r_fstart  <= PW'(FIELDS_START_RESET);
            r_foff    <= '0;
            r_fon     <= 1'b0;
        end else if (i_adv) begin
            if (i_item.in_last) begin
                r_pos     <= '0;
                r_hdr     <= '0;
                r_present <= '0;
                r_chain   <= 1'b0;
                r_fstart  <= PW'(FIELDS_START_RESET);
                r_foff    <= '0;
                r_fon     <= 1'b0;
            end else begin
                r_pos     <= n_pos;
                r_hdr     <= n_hdr;
                r_present <= n_present;
                r_chain   <= n_chain;
                r_fstart  <= n_fstart;
                r_foff    <= n_foff;
                r_fon     <= n_fon;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_freq <= FREQ_RESET_MHZ;
            r_mark <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_idx))
                REG_CHANNEL_FREQ:  r_freq <= i_cfg_data[15:0];
                REG_MARK_INJECTED: r_mark <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && i_item.in_last) |=> (r_pos == '0 && !r_chain && !r_fon))
        else $error("frame state not cleared after last item");

    a_pos_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && !i_item.in_last) |=> (r_pos >= $past(r_pos)))
        else $error("byte position went backwards within a frame");

    a_offset_past_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fon |-> (XW'(r_foff) >= XW'(FIELDS_START_RESET)
                   && XW'(r_fstart) >= XW'(FIELDS_START_RESET)))
        else $error("channel offset inside fixed radiotap header");

endmodule

FILE: design/rtcp_out_stage.sv
// Result register of the radiotap channel patcher: holds one finished item.
// Depends on rtcp_pkg.
module rtcp_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  rtcp_pkg::t_result i_res,
    output logic              o_free,
    output logic              o_valid,
    input  logic              i_ready,
    output rtcp_pkg::t_result o_res
);
    import rtcp_pkg::*;

    logic    r_valid;
    logic    n_valid;
    t_result r_res;

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_comb begin
        n_valid = r_valid;
        if (o_free) begin
            n_valid = i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule

FILE: design/radiotap_channel_patcher.sv
// Top level of the radiotap channel patcher: input register, patch logic, result register.
// Depends on rtcp_pkg, rtcp_in_if, rtcp_out_if, rtcp_in_stage, rtcp_core, rtcp_out_stage.
//
//   Port        Dir  Handshake    Carries
//   i_in        in   valid/ready  in_byte, in_last
//   o_out       out  valid/ready  out_byte, out_last, frame_status
//   i_cfg_*     in   write enable register index, write data (no read-back)
//
// One byte per cycle sustained while o_out is ready; output valid comes from the result register.
// Each byte passes the input register, the combinational patch logic, then the result register.
// Synchronous active-low reset clears frame state and restores register defaults.
// A stall on o_out holds the result register and backs up into the input register.
module radiotap_channel_patcher #(
    parameter int unsigned POSITION_BITS = rtcp_pkg::POSITION_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    rtcp_in_if.sink                         i_in,
    rtcp_out_if.source                      o_out,
    input  logic                            i_cfg_we,
    input  logic [rtcp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [rtcp_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import rtcp_pkg::*;

    t_item   in_item;
    t_item   stage_item;
    t_result core_res;
    t_result out_res;
    logic    adv;
    logic    down_free;

    assign in_item.in_byte = i_in.in_byte;
    assign in_item.in_last = i_in.in_last;

    rtcp_in_stage u_in_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in.valid),
        .o_ready     (i_in.ready),
        .i_item      (in_item),
        .i_down_free (down_free),
        .o_adv       (adv),
        .o_item      (stage_item)
    );

    rtcp_core #(
        .POSITION_BITS (POSITION_BITS)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_adv      (adv),
        .i_item     (stage_item),
        .o_res      (core_res)
    );

    rtcp_out_stage u_out_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (adv),
        .i_res   (core_res),
        .o_free  (down_free),
        .o_valid (o_out.valid),
        .i_ready (o_out.ready),
        .o_res   (out_res)
    );

    assign o_out.out_byte     = out_res.out_byte;
    assign o_out.out_last     = out_res.out_last;
    assign o_out.frame_status = out_res.frame_status;

endmodule
